// ----- hdl/shell_line_tokenizer_defines.svh -----
// Assertion macros for the shell line tokenizer.
// Both macros compile to nothing when SYNTH is defined.
`ifndef SHELL_LINE_TOKENIZER_DEFINES_SVH
`define SHELL_LINE_TOKENIZER_DEFINES_SVH

`ifndef SYNTH

// Check a condition in the same cycle as its trigger.
`define SLT_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("shell_line_tokenizer: same-cycle check failed");

// Check a condition in the cycle after its trigger.
`define SLT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("shell_line_tokenizer: next-cycle check failed");

`else

`define SLT_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define SLT_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- hdl/slt_pkg.sv -----
package slt_pkg;

    typedef enum logic [1:0] {
        MODE_BETWEEN = 2'd0,
        MODE_IN_ARG  = 2'd1,
        MODE_COMMENT = 2'd2,
        MODE_IGNORE  = 2'd3
    } scan_mode_t;

    typedef enum logic [1:0] {
        QUOTE_NONE   = 2'd0,
        QUOTE_SINGLE = 2'd1,
        QUOTE_DOUBLE = 2'd2
    } quote_t;

    typedef enum logic [2:0] {
        KIND_BYTE  = 3'd0,
        KIND_END   = 3'd1,
        KIND_DONE  = 3'd2,
        KIND_MANY  = 3'd3,
        KIND_QUOTE = 3'd4
    } kind_t;

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_EOL  = 1'b1;

    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;

    localparam logic [7:0] MAX_ARGS_RESET = 8'd16;

    // Count of results one item can give: 0..3.
    typedef logic [1:0] res_count_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] out_byte;
        logic [7:0] arg_index;
        logic [7:0] arg_count;
        logic       last;
    } result_t;

    typedef struct packed {
        result_t [2:0] res;
        res_count_t    n;
    } result_set_t;

    typedef struct packed {
        scan_mode_t mode;
        quote_t     quote;
        logic       esc;
        logic [7:0] args;
    } line_state_t;

    localparam line_state_t LINE_STATE_RESET = '{
        mode:  MODE_BETWEEN,
        quote: QUOTE_NONE,
        esc:   1'b0,
        args:  8'd0
    };

    function automatic result_t make_result(kind_t k, logic [7:0] b,
                                            logic [7:0] idx, logic [7:0] cnt);
        result_t r;
        r.kind      = k;
        r.out_byte  = b;
        r.arg_index = idx;
        r.arg_count = cnt;
        r.last      = 1'b0;
        return r;
    endfunction

    function automatic logic is_space(logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

endpackage

// ----- hdl/slt_decode.sv -----
module slt_decode (
    input  logic                 op,
    input  logic [7:0]           line_byte,
    input  slt_pkg::line_state_t state,
    input  logic [7:0]           max_args,
    output slt_pkg::line_state_t state_next,
    output slt_pkg::result_set_t results
);
    import slt_pkg::*;

    logic ws;
    logic in_arg;
    quote_t q;

    assign ws = is_space(line_byte);
    assign q  = (line_byte == CH_SQUOTE) ? QUOTE_SINGLE : QUOTE_DOUBLE;

    always_comb
    begin
        state_next = state;
        results    = '0;
        in_arg     = 1'b0;
        if (op == OP_EOL)
        begin
            state_next = LINE_STATE_RESET;
            unique case (state.mode)
                MODE_IN_ARG:
                begin
                    // A pending backslash is kept as a literal byte.
                    priority if (state.esc && (state.quote != QUOTE_NONE))
                    begin
                        results.res[0] = make_result(KIND_BYTE, CH_BSLASH, state.args, 8'd0);
                        results.res[1] = make_result(KIND_QUOTE, 8'd0, 8'd0, 8'd0);
                        results.n      = 2'd2;
                    end
                    else if (state.esc)
                    begin
                        results.res[0] = make_result(KIND_BYTE, CH_BSLASH, state.args, 8'd0);
                        results.res[1] = make_result(KIND_END, 8'd0, state.args, 8'd0);
                        results.res[2] = make_result(KIND_DONE, 8'd0, 8'd0,
                                                     state.args + 8'd1);
                        results.n      = 2'd3;
                    end
                    else if (state.quote != QUOTE_NONE)
                    begin
                        results.res[0] = make_result(KIND_QUOTE, 8'd0, 8'd0, 8'd0);
                        results.n      = 2'd1;
                    end
                    else
                    begin
                        results.res[0] = make_result(KIND_END, 8'd0, state.args, 8'd0);
                        results.res[1] = make_result(KIND_DONE, 8'd0, 8'd0,
                                                     state.args + 8'd1);
                        results.n      = 2'd2;
                    end
                end
                MODE_BETWEEN, MODE_COMMENT:
                begin
                    results.res[0] = make_result(KIND_DONE, 8'd0, 8'd0, state.args);
                    results.n      = 2'd1;
                end
                MODE_IGNORE:
                begin
                    // Drop the line silently after an error.
                end
            endcase
        end
        else
        begin
            unique case (state.mode)
                MODE_BETWEEN:
                begin
                    priority if (ws)
                    begin
                    end
                    else if (line_byte == CH_HASH)
                    begin
                        state_next.mode = MODE_COMMENT;
                    end
                    else if (state.args >= max_args)
                    begin
                        state_next.mode = MODE_IGNORE;
                        results.res[0]  = make_result(KIND_MANY, 8'd0, 8'd0, 8'd0);
                        results.n       = 2'd1;
                    end
                    else
                    begin
                        state_next.mode = MODE_IN_ARG;
                        in_arg          = 1'b1;
                    end
                end
                MODE_IN_ARG:
                begin
                    in_arg = 1'b1;
                end
                MODE_COMMENT, MODE_IGNORE:
                begin
                end
            endcase

            if (in_arg)
            begin
                priority if (state.esc)
                begin
                    state_next.esc = 1'b0;
                    results.res[0] = make_result(KIND_BYTE, line_byte, state.args, 8'd0);
                    results.n      = 2'd1;
                end
                else if (ws && (state.quote == QUOTE_NONE))
                begin
                    state_next.mode = MODE_BETWEEN;
                    state_next.args = state.args + 8'd1;
                    results.res[0]  = make_result(KIND_END, 8'd0, state.args, 8'd0);
                    results.n       = 2'd1;
                end
                else if ((line_byte == CH_SQUOTE) || (line_byte == CH_DQUOTE))
                begin
                    priority if (state.quote == QUOTE_NONE)
                    begin
                        state_next.quote = q;
                    end
                    else if (state.quote == q)
                    begin
                        state_next.quote = QUOTE_NONE;
                    end
                    else
                    begin
                        results.res[0] = make_result(KIND_BYTE, line_byte, state.args, 8'd0);
                        results.n      = 2'd1;
                    end
                end
                else if ((line_byte == CH_BSLASH) && (state.quote != QUOTE_SINGLE))
                begin
                    state_next.esc = 1'b1;
                end
                else
                begin
                    results.res[0] = make_result(KIND_BYTE, line_byte, state.args, 8'd0);
                    results.n      = 2'd1;
                end
            end
        end

        // Mark the final result of the item.
        for (int i = 0; i < 3; i++)
        begin
            results.res[i].last = (results.n == 2'(i + 1));
        end
    end

endmodule

// ----- hdl/slt_result_buf.sv -----
module slt_result_buf (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  slt_pkg::result_set_t set,
    output logic                 can_load,
    output logic                 out_valid,
    input  logic                 out_ready,
    output slt_pkg::result_t     head,
    output slt_pkg::res_count_t  count
);
    import slt_pkg::*;

    res_count_t    count_reg;
    res_count_t    count_next;
    result_t [2:0] entries_reg;
    result_t [2:0] entries_next;
    logic          pop;

    assign out_valid = (count_reg != 2'd0);
    assign pop       = out_valid && out_ready;
    // Refill when empty or when the last held result leaves this cycle.
    assign can_load  = (count_reg == 2'd0) || ((count_reg == 2'd1) && out_ready);
    assign head      = entries_reg[0];
    assign count     = count_reg;

    always_comb
    begin
        count_next   = count_reg;
        entries_next = entries_reg;
        if (load)
        begin
            entries_next = set.res;
            count_next   = set.n;
        end
        else if (pop)
        begin
            entries_next[0] = entries_reg[1];
            entries_next[1] = entries_reg[2];
            count_next      = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entries_reg <= entries_next;
    end

endmodule

// ----- hdl/shell_line_tokenizer.sv -----
// Shell line tokenizer: takes a command line one byte per item (op 0), closed by an
// end-of-line item (op 1), and splits it into arguments with shell quoting rules:
// whitespace separates, '#' at an argument start comments out the rest of the line,
// single and double quotes are stripped, and a backslash outside single quotes makes
// the next byte literal. Each item gives zero to three results (argument byte, end
// of argument, line done with count, or an error). An accepted item is decoded from
// the input register and its results load into the output buffer when it can take
// them. Items with zero or one result flow at one per cycle while out_ready is high;
// an item with more holds back the next, as results leave one per cycle through a
// single output port. max_args is set via cfg_wr_en/cfg_wr_data and resets to 16.
`include "shell_line_tokenizer_defines.svh"

module shell_line_tokenizer (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       op,
    input  logic [7:0] line_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [2:0] kind,
    output logic [7:0] out_byte,
    output logic [7:0] arg_index,
    output logic [7:0] arg_count,
    output logic       last,
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data
);
    import slt_pkg::*;

    // Input register: one item waiting for the decoder.
    logic        in_valid_reg;
    logic        op_reg;
    logic [7:0]  byte_reg;

    // Line scanning state and the configured argument limit.
    line_state_t state_reg;
    line_state_t state_next;
    logic [7:0]  max_args_reg;

    result_set_t results;
    result_t     head;
    res_count_t  buf_count;
    logic        can_load;
    logic        consume;
    logic        take_in;

    // An item with no results never waits on the output side.
    assign consume  = in_valid_reg && ((results.n == 2'd0) || can_load);
    assign in_ready = !in_valid_reg || consume;
    assign take_in  = in_valid && in_ready;

    slt_decode u_decode (
        .op         (op_reg),
        .line_byte  (byte_reg),
        .state      (state_reg),
        .max_args   (max_args_reg),
        .state_next (state_next),
        .results    (results)
    );

    slt_result_buf u_result_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (consume && (results.n != 2'd0)),
        .set       (results),
        .can_load  (can_load),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .head      (head),
        .count     (buf_count)
    );

    assign kind      = head.kind;
    assign out_byte  = head.out_byte;
    assign arg_index = head.arg_index;
    assign arg_count = head.arg_count;
    assign last      = head.last;

    // Hold the input item until the decoder retires it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (take_in)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (consume)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            op_reg   <= op;
            byte_reg <= line_byte;
        end
    end

    // Advance the scanner only when the item is retired.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= LINE_STATE_RESET;
        end
        else if (consume)
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_args_reg <= MAX_ARGS_RESET;
        end
        else if (cfg_wr_en)
        begin
            max_args_reg <= cfg_wr_data;
        end
    end

    // The only result left in the buffer must close its item.
    `SLT_ASSERT_SAME(a_single_is_last, clk, rst_n, buf_count == 2'd1, head.last)
    // A result with more behind it never closes its item.
    `SLT_ASSERT_SAME(a_more_not_last, clk, rst_n, buf_count > 2'd1, !head.last)
    // End of line always returns the scanner to its idle state.
    `SLT_ASSERT_NEXT(a_eol_clears, clk, rst_n, consume && (op_reg == OP_EOL), state_reg == LINE_STATE_RESET)
    // An escape can only be pending inside an argument.
    `SLT_ASSERT_SAME(a_esc_in_arg, clk, rst_n, state_reg.mode != MODE_IN_ARG, !state_reg.esc)

endmodule

// ----- tb/sv/tb_shell_line_tokenizer.sv -----
`timescale 1ns / 1ps

module tb_shell_line_tokenizer;

    import slt_pkg::*;

    localparam int SETTLE_CYCLES = 8;    // covers items still in flight that owe no result
    localparam int WATCHDOG      = 2000; // cycles with no handshake at all
    localparam int PHASE_ITEMS   = 80;   // random items per max_args setting

    // What the driver pulls off its queue: a line item, a register write, or a pause
    // that holds the sender until every owed result has come back.
    typedef enum logic [1:0] {
        FEED_ITEM,
        FEED_CFG,
        FEED_DRAIN
    } feed_what_e;

    typedef struct {
        feed_what_e what;
        logic       opv;
        logic [7:0] val;
        bit         steady;
    } feed_t;

    logic       clk         = 1'b0;
    logic       rst_n       = 1'b0;
    logic       in_valid    = 1'b0;
    logic       in_ready;
    logic       op          = OP_BYTE;
    logic [7:0] line_byte   = 8'd0;
    logic       out_valid;
    logic       out_ready   = 1'b0;
    logic [2:0] kind;
    logic [7:0] out_byte;
    logic [7:0] arg_index;
    logic [7:0] arg_count;
    logic       last;
    logic       cfg_wr_en   = 1'b0;
    logic [7:0] cfg_wr_data = 8'd0;

    shell_line_tokenizer dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .op          (op),
        .line_byte   (line_byte),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .kind        (kind),
        .out_byte    (out_byte),
        .arg_index   (arg_index),
        .arg_count   (arg_count),
        .last        (last),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predicted tokenizer state. Lives across the whole run, since reset
    // is applied only once; max_args follows every register write.
    // ------------------------------------------------------------------
    scan_mode_t tk_mode  = MODE_BETWEEN;
    quote_t     tk_quote = QUOTE_NONE;
    bit         tk_esc   = 1'b0;
    logic [7:0] tk_args  = 8'd0;
    logic [7:0] tk_max   = MAX_ARGS_RESET;

    result_t owed_results[$]; // results predicted but not yet seen, oldest first
    feed_t   line_feed[$];    // stimulus waiting for the driver

    bit steady = 1'b0;        // phase with no gaps on either side
    int gap_left = 0;
    int quiet_cycles = 0;
    int rx_hold = 0;
    int idle_cycles = 0;

    int n_queued = 0;
    int n_items = 0;
    int n_eol = 0;
    int n_cfg = 0;
    int n_checked = 0;
    int n_done = 0;
    int n_many = 0;
    int n_open = 0;
    int n_bad = 0;

    function automatic bit is_blank(logic [7:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    // Advance the predicted tokenizer by one accepted item and queue what it owes.
    task automatic split_step(input logic opv, input logic [7:0] c);
        result_t got [3];
        int      n;
        bit      skip;
        n = 0;
        skip = 1'b0;
        if (opv == OP_EOL) begin
            if (tk_mode == MODE_IN_ARG) begin
                // a dangling backslash survives as a literal byte
                if (tk_esc) begin
                    got[n] = '{KIND_BYTE, CH_BSLASH, tk_args, 8'd0, 1'b0};
                    n++;
                end
                if (tk_quote != QUOTE_NONE) begin
                    got[n] = '{KIND_QUOTE, 8'd0, 8'd0, 8'd0, 1'b0};
                    n++;
                end
                else begin
                    got[n] = '{KIND_END, 8'd0, tk_args, 8'd0, 1'b0};
                    n++;
                    tk_args = tk_args + 8'd1;
                    got[n] = '{KIND_DONE, 8'd0, 8'd0, tk_args, 1'b0};
                    n++;
                end
            end
            else if (tk_mode != MODE_IGNORE) begin
                got[n] = '{KIND_DONE, 8'd0, 8'd0, tk_args, 1'b0};
                n++;
            end
            tk_mode = MODE_BETWEEN;
            tk_quote = QUOTE_NONE;
            tk_esc = 1'b0;
            tk_args = 8'd0;
        end
        else begin
            if (tk_mode == MODE_BETWEEN) begin
                if (is_blank(c)) begin
                    skip = 1'b1;
                end
                else if (c == CH_HASH) begin
                    tk_mode = MODE_COMMENT;
                    skip = 1'b1;
                end
                else if (tk_args >= tk_max) begin
                    tk_mode = MODE_IGNORE;
                    got[n] = '{KIND_MANY, 8'd0, 8'd0, 8'd0, 1'b0};
                    n++;
                    skip = 1'b1;
                end
                else begin
                    tk_mode = MODE_IN_ARG;
                end
            end
            if (!skip && tk_mode == MODE_IN_ARG) begin
                if (tk_esc) begin
                    tk_esc = 1'b0;
                    got[n] = '{KIND_BYTE, c, tk_args, 8'd0, 1'b0};
                    n++;
                end
                else if (is_blank(c) && tk_quote == QUOTE_NONE) begin
                    got[n] = '{KIND_END, 8'd0, tk_args, 8'd0, 1'b0};
                    n++;
                    tk_args = tk_args + 8'd1;
                    tk_mode = MODE_BETWEEN;
                end
                else if (c == CH_SQUOTE || c == CH_DQUOTE) begin
                    // open, close, or the other kind taken literally
                    if (tk_quote == QUOTE_NONE)
                        tk_quote = (c == CH_SQUOTE) ? QUOTE_SINGLE : QUOTE_DOUBLE;
                    else if ((tk_quote == QUOTE_SINGLE) == (c == CH_SQUOTE))
                        tk_quote = QUOTE_NONE;
                    else begin
                        got[n] = '{KIND_BYTE, c, tk_args, 8'd0, 1'b0};
                        n++;
                    end
                end
                else if (c == CH_BSLASH && tk_quote != QUOTE_SINGLE) begin
                    tk_esc = 1'b1;
                end
                else begin
                    got[n] = '{KIND_BYTE, c, tk_args, 8'd0, 1'b0};
                    n++;
                end
            end
        end
        if (n > 0)
            got[n - 1].last = 1'b1;
        for (int i = 0; i < n; i++)
            owed_results.push_back(got[i]);
    endtask

    // ------------------------------------------------------------------
    // Driver: present one item at a time, hold it until taken, then wait
    // the drawn gap. Register writes and pauses wait for a quiet block.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        feed_t      nx;
        logic       nv_valid;
        logic       nv_op;
        logic [7:0] nv_byte;
        logic       nv_cfg_en;
        logic [7:0] nv_cfg;
        if (!rst_n) begin
            in_valid <= 1'b0;
            op <= OP_BYTE;
            line_byte <= 8'd0;
            cfg_wr_en <= 1'b0;
            cfg_wr_data <= 8'd0;
        end
        else begin
            nv_valid = in_valid;
            nv_op = op;
            nv_byte = line_byte;
            nv_cfg_en = 1'b0;
            nv_cfg = cfg_wr_data;
            if (in_valid && in_ready) begin
                split_step(op, line_byte);
                n_items++;
                if (op == OP_EOL)
                    n_eol++;
                nv_valid = 1'b0;
            end
            // count edges with nothing owed and nothing offered
            if (owed_results.size() == 0 && !nv_valid)
                quiet_cycles++;
            else
                quiet_cycles = 0;
            if (!nv_valid) begin
                if (gap_left > 0) begin
                    gap_left--;
                end
                else if (line_feed.size() > 0) begin
                    nx = line_feed[0];
                    case (nx.what)
                        FEED_ITEM: begin
                            void'(line_feed.pop_front());
                            nv_valid = 1'b1;
                            nv_op = nx.opv;
                            nv_byte = nx.val;
                            gap_left = steady ? 0 : $urandom_range(0, 9);
                        end
                        default: begin
                            if (quiet_cycles >= SETTLE_CYCLES) begin
                                void'(line_feed.pop_front());
                                if (nx.what == FEED_CFG) begin
                                    nv_cfg_en = 1'b1;
                                    nv_cfg = nx.val;
                                    tk_max = nx.val;
                                    steady <= nx.steady;
                                    n_cfg++;
                                end
                                quiet_cycles = 0;
                            end
                        end
                    endcase
                end
            end
            in_valid <= nv_valid;
            op <= nv_op;
            line_byte <= nv_byte;
            cfg_wr_en <= nv_cfg_en;
            cfg_wr_data <= nv_cfg;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: take results with random stalls, check each against the
    // oldest prediction.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        int      w;
        if (!rst_n) begin
            out_ready <= 1'b0;
            rx_hold <= 0;
        end
        else if (out_valid && out_ready) begin
            n_checked++;
            case (kind)
                KIND_DONE:  n_done++;
                KIND_MANY:  n_many++;
                KIND_QUOTE: n_open++;
                default: ;
            endcase
            if (owed_results.size() == 0) begin
                n_bad++;
                $display("%0t: unexpected result kind %0d byte %02h idx %0d cnt %0d last %0b",
                         $time, kind, out_byte, arg_index, arg_count, last);
            end
            else begin
                want = owed_results.pop_front();
                if (kind !== want.kind || out_byte !== want.out_byte ||
                    arg_index !== want.arg_index || arg_count !== want.arg_count ||
                    last !== want.last) begin
                    n_bad++;
                    $display({"%0t: expected kind %0d byte %02h idx %0d cnt %0d last %0b,",
                              " got kind %0d byte %02h idx %0d cnt %0d last %0b"},
                             $time, want.kind, want.out_byte, want.arg_index,
                             want.arg_count, want.last,
                             kind, out_byte, arg_index, arg_count, last);
                end
            end
            w = steady ? 0 : $urandom_range(0, 9);
            if (w == 0) begin
                out_ready <= 1'b1;
            end
            else begin
                out_ready <= 1'b0;
                rx_hold <= w;
            end
        end
        else if (!out_ready) begin
            if (rx_hold <= 1)
                out_ready <= 1'b1;
            if (rx_hold > 0)
                rx_hold <= rx_hold - 1;
        end
    end

    // Drop the run if the handshakes stop moving.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_wr_en) begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= WATCHDOG) begin
            $display("timeout after %0d idle cycles, %0d results still owed",
                     idle_cycles, owed_results.size());
            $display("shell_line_tokenizer: mismatch");
            $finish;
        end
        else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus queue helpers
    // ------------------------------------------------------------------
    task automatic push_byte(input logic [7:0] c);
        line_feed.push_back('{FEED_ITEM, OP_BYTE, c, 1'b0});
        n_queued++;
    endtask

    // line_byte is a don't-care with end of line; randomize it anyway
    task automatic push_eol();
        line_feed.push_back('{FEED_ITEM, OP_EOL, 8'($urandom_range(1, 255)), 1'b0});
        n_queued++;
    endtask

    function automatic logic [7:0] blank_byte();
        if ($urandom_range(0, 2) == 0)
            return CH_SPACE;
        return 8'($urandom_range(CH_TAB, CH_CR));
    endfunction

    function automatic logic [7:0] plain_byte();
        logic [7:0] c;
        do
            c = 8'($urandom_range(1, 255));
        while (is_blank(c) || c == CH_SQUOTE || c == CH_DQUOTE || c == CH_BSLASH);
        return c;
    endfunction

    initial
    begin
        // Directed lines, 8'h00 closes a line: lone comment; empty quotes,
        // the other quote inside double quotes and a backslash ending the line;
        // open single quote with a literal backslash; open double quote with a
        // pending escape; extreme bytes and an escaped blank.
        logic [7:0] opening [24] = '{
            CH_HASH, 8'h00,
            CH_SQUOTE, CH_SQUOTE, CH_SPACE, CH_DQUOTE, 8'h61, CH_SQUOTE, 8'h62,
            CH_DQUOTE, CH_TAB, CH_BSLASH, 8'h00,
            CH_SQUOTE, CH_BSLASH, 8'h00,
            CH_DQUOTE, CH_BSLASH, 8'h00,
            8'hFF, CH_BSLASH, CH_SPACE, 8'h01, 8'h00
        };
        int         stop_at;
        int         mid;
        int         style;
        int         words;
        bit         drained;
        logic [7:0] c;
        logic [7:0] q;

        foreach (opening[i]) begin
            if (opening[i] == 8'h00)
                push_eol();
            else
                push_byte(opening[i]);
        end

        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: c = 8'd3;
                1: c = 8'd1;
                2: c = 8'd255;
                3: c = 8'd2;
                default: c = 8'($urandom_range(4, 254));
            endcase
            line_feed.push_back('{FEED_CFG, OP_BYTE, c, (ph == 1 || ph == 3)});
            stop_at = n_queued + PHASE_ITEMS;
            mid = n_queued + PHASE_ITEMS / 2;
            drained = 1'b0;
            while (n_queued < stop_at) begin
                // hold the sender once per phase until the block is empty
                if (!drained && n_queued >= mid) begin
                    line_feed.push_back('{FEED_DRAIN, OP_BYTE, 8'd0, 1'b0});
                    drained = 1'b1;
                end
                style = $urandom_range(0, 9);
                if (style == 9) begin
                    // noise: random bytes heavy in the special characters
                    repeat ($urandom_range(1, 10)) begin
                        case ($urandom_range(0, 9))
                            0: push_byte(CH_SQUOTE);
                            1: push_byte(CH_DQUOTE);
                            2: push_byte(CH_BSLASH);
                            3: push_byte(CH_HASH);
                            4: push_byte(blank_byte());
                            default: push_byte(8'($urandom_range(1, 255)));
                        endcase
                    end
                end
                else begin
                    if ($urandom_range(0, 3) == 0)
                        push_byte(blank_byte());
                    words = $urandom_range(0, 5);
                    for (int w = 0; w < words; w++) begin
                        if (w > 0)
                            repeat ($urandom_range(1, 2)) push_byte(blank_byte());
                        repeat ($urandom_range(1, 3)) begin
                            case ($urandom_range(0, 4))
                                0: repeat ($urandom_range(1, 3)) push_byte(plain_byte());
                                1: begin
                                    push_byte(CH_SQUOTE);
                                    repeat ($urandom_range(0, 3)) begin
                                        do
                                            c = 8'($urandom_range(1, 255));
                                        while (c == CH_SQUOTE);
                                        push_byte(c);
                                    end
                                    push_byte(CH_SQUOTE);
                                end
                                2: begin
                                    push_byte(CH_DQUOTE);
                                    repeat ($urandom_range(0, 3)) begin
                                        if ($urandom_range(0, 3) == 0) begin
                                            push_byte(CH_BSLASH);
                                            push_byte(8'($urandom_range(1, 255)));
                                        end
                                        else begin
                                            do
                                                c = 8'($urandom_range(1, 255));
                                            while (c == CH_DQUOTE || c == CH_BSLASH);
                                            push_byte(c);
                                        end
                                    end
                                    push_byte(CH_DQUOTE);
                                end
                                3: begin
                                    push_byte(CH_BSLASH);
                                    push_byte(8'($urandom_range(1, 255)));
                                end
                                default: begin
                                    q = $urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE;
                                    push_byte(q);
                                    push_byte(q);
                                end
                            endcase
                        end
                    end
                    // broken endings: a quote left open, or a trailing backslash
                    if (style == 7) begin
                        push_byte($urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE);
                        repeat ($urandom_range(0, 2)) push_byte(plain_byte());
                    end
                    else if (style == 8) begin
                        push_byte(CH_BSLASH);
                    end
                    if ($urandom_range(0, 5) == 0) begin
                        push_byte(blank_byte());
                        push_byte(CH_HASH);
                        repeat ($urandom_range(0, 4)) push_byte(8'($urandom_range(1, 255)));
                    end
                    else if ($urandom_range(0, 4) == 0) begin
                        push_byte(blank_byte());
                    end
                end
                push_eol();
            end
        end

        // release reset, then let the queue run dry and the block settle
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        while (line_feed.size() > 0 || in_valid || owed_results.size() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (owed_results.size() != 0) begin
            n_bad++;
            $display("%0t: %0d results never arrived", $time, owed_results.size());
        end

        $display("ran %0d items (%0d line ends) over %0d max_args settings, checked %0d results",
                 n_items, n_eol, n_cfg, n_checked);
        $display("saw %0d finished lines, %0d too-many errors, %0d open-quote errors",
                 n_done, n_many, n_open);
        if (n_bad == 0)
            $display("shell_line_tokenizer: match");
        else
            $display("shell_line_tokenizer: mismatch");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/slt_pkg.sv
hdl/slt_decode.sv
hdl/slt_result_buf.sv
hdl/shell_line_tokenizer.sv
tb/sv/tb_shell_line_tokenizer.sv
